// ----- rtl/mics_pkg.sv -----
`timescale 1ns / 1ps
package mics_pkg;

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] key_state;
      logic [31:0] mouse_x;
      logic [31:0] mouse_y;
      logic [13:0] load_index;
      logic [31:0] load_data;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] pc_after;
      logic        dest_written;
      logic [4:0]  dest_reg;
      logic [31:0] dest_value;
      logic        gfx_written;
   } rsp_type;

   // request modes
   localparam logic [1:0] MODE_EXEC    = 2'd0;
   localparam logic [1:0] MODE_LOAD    = 2'd1;
   localparam logic [1:0] MODE_RESTART = 2'd2;

   // status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_FETCH    = 2'd1;
   localparam logic [1:0] ST_RANGE    = 2'd2;
   localparam logic [1:0] ST_MISALIGN = 2'd3;

   // configuration register indexes
   localparam logic [1:0] CSR_CODE_OFFSET = 2'd0;
   localparam logic [1:0] CSR_GFX_ADDRESS = 2'd1;
   localparam logic [1:0] CSR_KEY_ADDRESS = 2'd2;

   // fixed mapped load addresses
   localparam logic [31:0] MOUSE_Y_ADDR = 32'h0000_00FC;
   localparam logic [31:0] MOUSE_X_ADDR = 32'h0000_00FB;

   // primary opcodes
   localparam logic [5:0] OP_SPECIAL = 6'h00;
   localparam logic [5:0] OP_REGIMM  = 6'h01;
   localparam logic [5:0] OP_J       = 6'h02;
   localparam logic [5:0] OP_JAL     = 6'h03;
   localparam logic [5:0] OP_BEQ     = 6'h04;
   localparam logic [5:0] OP_BNE     = 6'h05;
   localparam logic [5:0] OP_BLEZ    = 6'h06;
   localparam logic [5:0] OP_BGTZ    = 6'h07;
   localparam logic [5:0] OP_ADDI    = 6'h08;
   localparam logic [5:0] OP_ADDIU   = 6'h09;
   localparam logic [5:0] OP_SLTI    = 6'h0A;
   localparam logic [5:0] OP_SLTIU   = 6'h0B;
   localparam logic [5:0] OP_ANDI    = 6'h0C;
   localparam logic [5:0] OP_ORI     = 6'h0D;
   localparam logic [5:0] OP_XORI    = 6'h0E;
   localparam logic [5:0] OP_LUI     = 6'h0F;
   localparam logic [5:0] OP_LB      = 6'h20;
   localparam logic [5:0] OP_LH      = 6'h21;
   localparam logic [5:0] OP_LW      = 6'h23;
   localparam logic [5:0] OP_LBU     = 6'h24;
   localparam logic [5:0] OP_LHU     = 6'h25;
   localparam logic [5:0] OP_SB      = 6'h28;
   localparam logic [5:0] OP_SH      = 6'h29;
   localparam logic [5:0] OP_SW      = 6'h2B;

   // REGIMM rt codes
   localparam logic [4:0] RI_BLTZ = 5'd0;
   localparam logic [4:0] RI_BGEZ = 5'd1;

   // SPECIAL function codes
   localparam logic [5:0] FN_SLL   = 6'd0;
   localparam logic [5:0] FN_SRL   = 6'd2;
   localparam logic [5:0] FN_SRA   = 6'd3;
   localparam logic [5:0] FN_SLLV  = 6'd4;
   localparam logic [5:0] FN_SRLV  = 6'd6;
   localparam logic [5:0] FN_SRAV  = 6'd7;
   localparam logic [5:0] FN_JR    = 6'd8;
   localparam logic [5:0] FN_JALR  = 6'd9;
   localparam logic [5:0] FN_MFHI  = 6'd16;
   localparam logic [5:0] FN_MTHI  = 6'd17;
   localparam logic [5:0] FN_MFLO  = 6'd18;
   localparam logic [5:0] FN_MTLO  = 6'd19;
   localparam logic [5:0] FN_MULT  = 6'd24;
   localparam logic [5:0] FN_MULTU = 6'd25;
   localparam logic [5:0] FN_DIV   = 6'd26;
   localparam logic [5:0] FN_DIVU  = 6'd27;
   localparam logic [5:0] FN_ADD   = 6'd32;
   localparam logic [5:0] FN_ADDU  = 6'd33;
   localparam logic [5:0] FN_SUB   = 6'd34;
   localparam logic [5:0] FN_SUBU  = 6'd35;
   localparam logic [5:0] FN_AND   = 6'd36;
   localparam logic [5:0] FN_OR    = 6'd37;
   localparam logic [5:0] FN_XOR   = 6'd38;
   localparam logic [5:0] FN_NOR   = 6'd39;
   localparam logic [5:0] FN_SLT   = 6'd42;
   localparam logic [5:0] FN_SLTU  = 6'd43;

   localparam logic [4:0] LINK_REG = 5'd31;

endpackage

// ----- rtl/mics_regfile.sv -----
`timescale 1ns / 1ps
// 32 x 32 register file, two registered read ports, one write port.
// Entries read as zero until first written; entry 0 is always zero.
module mics_regfile (
   input  logic        clock,
   input  logic        reset,
   input  logic        rd_en,
   input  logic [4:0]  rd_addr_a,
   input  logic [4:0]  rd_addr_b,
   output logic [31:0] rd_data_a,
   output logic [31:0] rd_data_b,
   input  logic        wr_en,
   input  logic [4:0]  wr_addr,
   input  logic [31:0] wr_data
);

   logic [31:0] mem [32];
   logic [31:0] valid_ff;
   logic [31:0] data_a_ff;
   logic [31:0] data_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en && wr_addr != 5'd0) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && wr_addr != 5'd0) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         data_a_ff <= (valid_ff[rd_addr_a] && rd_addr_a != 5'd0) ? mem[rd_addr_a] : '0;
         data_b_ff <= (valid_ff[rd_addr_b] && rd_addr_b != 5'd0) ? mem[rd_addr_b] : '0;
      end
   end

   assign rd_data_a = data_a_ff;
   assign rd_data_b = data_b_ff;

endmodule

// ----- rtl/mics_dmem.sv -----
`timescale 1ns / 1ps
// Single-port word memory, read data registered.
module mics_dmem #(
   parameter int unsigned WORDS = 16384,
   parameter int unsigned AW    = 14
) (
   input  logic          clock,
   input  logic          en,
   input  logic          we,
   input  logic [AW-1:0] addr,
   input  logic [31:0]   wdata,
   output logic [31:0]   rdata
);

   logic [31:0] mem [WORDS];
   logic [31:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/mics_div.sv -----
`timescale 1ns / 1ps
// Unsigned restoring divider, one quotient bit a cycle.
module mics_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] quotient,
   output logic [31:0] remainder
);

   logic        run_ff;
   logic        done_ff;
   logic [4:0]  cnt_ff;
   logic [31:0] quo_ff;
   logic [31:0] rem_ff;
   logic [31:0] dvs_ff;
   logic [32:0] shifted;
   logic [32:0] diff;
   logic        qbit;

   assign shifted = {rem_ff, quo_ff[31]};
   assign diff    = shifted - {1'b0, dvs_ff};
   assign qbit    = ~diff[32];

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (run_ff) begin
         quo_ff <= {quo_ff[30:0], qbit};
         rem_ff <= qbit ? diff[31:0] : shifted[31:0];
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ----- rtl/mips_integer_core_step.sv -----
`timescale 1ns / 1ps
// Single-step MIPS-I integer core.
//
// Request channel: a request is taken at a rising edge with start high and
// busy low; req_data carries mode and the input words. Mode 0 runs one
// instruction, mode 1 writes one memory word, mode 2 restarts at
// code_offset, mode 3 does nothing.
// Response channel: every request gives exactly one response, shown on
// rsp_data for one cycle with rsp_valid high. The receiver cannot stall it.
// Configuration: csr_valid/csr_ready write channel, always ready. The user
// writes it only while the core is idle; the core does not enforce this.
// Flow: modes 1..3 and fetch faults answer from idle; ALU, branch and jump
// instructions, word stores, mapped loads, data faults and divides by zero
// finish after fetch and execute; other loads, byte and half stores pass a
// memory state, multiplies a multiply state, divides wait for the divider.
// Every step reads the instruction and data through the one port of the
// word memory, so one request is in flight at a time; busy drops in the
// cycle the response is shown, and the next request may be taken then.
// Reset: registers, hi/lo and pc clear at once (register file uses valid
// bits); the word memory is not cleared and must be loaded in mode 1.
module mips_integer_core_step #(
   parameter int unsigned MEM_BYTES = 65536
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  mics_pkg::req_type   req_data,
   output logic                rsp_valid,
   output mics_pkg::rsp_type   rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [15:0]         csr_wdata
);

   localparam int unsigned MemWordsInt = MEM_BYTES / 4;
   localparam int unsigned AW          = $clog2(MemWordsInt);
   localparam logic [31:0] MemBytes    = 32'(MEM_BYTES);
   localparam logic [31:0] MemWords    = 32'(MemWordsInt);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_FETCH = 6'b000010,
      S_EXEC  = 6'b000100,
      S_MEM   = 6'b001000,
      S_MUL   = 6'b010000,
      S_DIV   = 6'b100000
   } state_type;

   state_type         state_ff, state_in;
   mics_pkg::req_type req_ff;
   logic [31:0]       pc_ff, pc_in;
   logic [31:0]       hi_ff, hi_in;
   logic [31:0]       lo_ff, lo_in;
   logic [31:0]       ins_ff;
   logic [31:0]       addr_ff;
   logic [31:0]       npc_ff;
   logic [63:0]       prod_ff;
   logic              mneg_ff;
   logic              qneg_ff;
   logic              rneg_ff;
   logic [15:0]       code_offset_ff;
   logic [15:0]       gfx_address_ff;
   logic [15:0]       key_address_ff;
   logic              rsp_valid_ff;
   mics_pkg::rsp_type rsp_ff, rsp_in;

   logic              accept;
   logic              fin;
   logic              fin_wr;
   logic [4:0]        fin_reg;
   logic [31:0]       fin_val;
   logic              hi_we, lo_we;

   // memory and register file hooks
   logic              dm_en, dm_we;
   logic [AW-1:0]     dm_addr;
   logic [31:0]       dm_wdata, dm_rdata;
   logic              rf_rd_en;
   logic [31:0]       rs, rt;

   // divider
   logic              div_start, div_done;
   logic [31:0]       div_a, div_b, div_q, div_r;

   // decode
   logic [5:0]  op, fn;
   logic [4:0]  rsn, rtn, rdn, sh;
   logic [31:0] imm, zimm, ea, npc, br, jtgt, ma, mb;
   logic [63:0] mprod;
   logic [1:0]  st_b, st_h, st_w;
   logic [4:0]  bsh;
   logic [31:0] byte_w, half_w;

   function automatic logic [1:0] chk_addr(input logic [31:0] a, input logic [31:0] size);
      logic [1:0] r;
      r = mics_pkg::ST_OK;
      if (a > MemBytes - size) begin
         r = mics_pkg::ST_RANGE;
      end else if ((a & (size - 32'd1)) != 32'd0) begin
         r = mics_pkg::ST_MISALIGN;
      end
      return r;
   endfunction

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign op   = ins_ff[31:26];
   assign rsn  = ins_ff[25:21];
   assign rtn  = ins_ff[20:16];
   assign rdn  = ins_ff[15:11];
   assign sh   = ins_ff[10:6];
   assign fn   = ins_ff[5:0];
   assign imm  = {{16{ins_ff[15]}}, ins_ff[15:0]};
   assign zimm = {16'd0, ins_ff[15:0]};
   assign ea   = rs + imm;
   assign npc  = pc_ff + 32'd4;
   assign br   = npc + {imm[29:0], 2'b00};
   assign jtgt = {16'd0, code_offset_ff} + ((npc & 32'hF000_0000) | {4'd0, ins_ff[25:0], 2'b00});
   assign st_b = chk_addr(ea, 32'd1);
   assign st_h = chk_addr(ea, 32'd2);
   assign st_w = chk_addr(ea, 32'd4);

   // signed ops work on magnitudes, sign fixed up afterwards
   assign ma    = (fn == mics_pkg::FN_MULT || fn == mics_pkg::FN_DIV) && rs[31] ? 32'd0 - rs : rs;
   assign mb    = (fn == mics_pkg::FN_MULT || fn == mics_pkg::FN_DIV) && rt[31] ? 32'd0 - rt : rt;
   assign mprod = ma * mb;

   // sub-word lanes of the fetched data word
   assign bsh    = {addr_ff[1:0], 3'b000};
   assign byte_w = (dm_rdata >> bsh) & 32'h0000_00FF;
   assign half_w = (dm_rdata >> {addr_ff[1], 4'b0000}) & 32'h0000_FFFF;

   assign div_a = ma;
   assign div_b = mb;

   // config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         code_offset_ff <= '0;
         gfx_address_ff <= '0;
         key_address_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            mics_pkg::CSR_CODE_OFFSET: code_offset_ff <= csr_wdata;
            mics_pkg::CSR_GFX_ADDRESS: gfx_address_ff <= csr_wdata;
            mics_pkg::CSR_KEY_ADDRESS: key_address_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // main sequencer
   always_comb begin
      state_in  = state_ff;
      pc_in     = pc_ff;
      hi_in     = hi_ff;
      lo_in     = lo_ff;
      hi_we     = 1'b0;
      lo_we     = 1'b0;
      fin       = 1'b0;
      fin_wr    = 1'b0;
      fin_reg   = '0;
      fin_val   = '0;
      rsp_in    = '0;
      dm_en     = 1'b0;
      dm_we     = 1'b0;
      dm_addr   = '0;
      dm_wdata  = '0;
      rf_rd_en  = 1'b0;
      div_start = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_data.mode)
                  mics_pkg::MODE_EXEC: begin
                     if (pc_ff > MemBytes - 32'd4) begin
                        fin = 1'b1;
                        rsp_in.status = mics_pkg::ST_FETCH;
                     end else if (pc_ff[1:0] != 2'b00) begin
                        fin = 1'b1;
                        rsp_in.status = mics_pkg::ST_MISALIGN;
                     end else begin
                        dm_en    = 1'b1;
                        dm_addr  = pc_ff[AW+1:2];
                        state_in = S_FETCH;
                     end
                  end
                  mics_pkg::MODE_LOAD: begin
                     fin = 1'b1;
                     if (32'(req_data.load_index) < MemWords) begin
                        dm_en    = 1'b1;
                        dm_we    = 1'b1;
                        dm_addr  = AW'(32'(req_data.load_index));
                        dm_wdata = req_data.load_data;
                     end
                  end
                  mics_pkg::MODE_RESTART: begin
                     fin   = 1'b1;
                     pc_in = {16'd0, code_offset_ff};
                  end
                  default: fin = 1'b1;
               endcase
            end
         end

         S_FETCH: begin
            rf_rd_en = 1'b1;
            state_in = S_EXEC;
         end

         S_EXEC: begin
            fin   = 1'b1;
            pc_in = npc;
            case (op)
               mics_pkg::OP_SPECIAL: begin
                  fin_reg = rdn;
                  case (fn)
                     mics_pkg::FN_SLL: begin fin_wr = 1'b1; fin_val = rt << sh; end
                     mics_pkg::FN_SRL: begin fin_wr = 1'b1; fin_val = rt >> sh; end
                     mics_pkg::FN_SRA: begin
                        fin_wr = 1'b1; fin_val = $unsigned($signed(rt) >>> sh);
                     end
                     mics_pkg::FN_SLLV: begin fin_wr = 1'b1; fin_val = rt << rs[4:0]; end
                     mics_pkg::FN_SRLV: begin fin_wr = 1'b1; fin_val = rt >> rs[4:0]; end
                     mics_pkg::FN_SRAV: begin
                        fin_wr = 1'b1; fin_val = $unsigned($signed(rt) >>> rs[4:0]);
                     end
                     mics_pkg::FN_JR: pc_in = rs;
                     mics_pkg::FN_JALR: begin fin_wr = 1'b1; fin_val = npc; pc_in = rs; end
                     mics_pkg::FN_MFHI: begin fin_wr = 1'b1; fin_val = hi_ff; end
                     mics_pkg::FN_MTHI: begin hi_we = 1'b1; hi_in = rs; end
                     mics_pkg::FN_MFLO: begin fin_wr = 1'b1; fin_val = lo_ff; end
                     mics_pkg::FN_MTLO: begin lo_we = 1'b1; lo_in = rs; end
                     mics_pkg::FN_MULT, mics_pkg::FN_MULTU: begin
                        fin      = 1'b0;
                        state_in = S_MUL;
                     end
                     mics_pkg::FN_DIV, mics_pkg::FN_DIVU: begin
                        if (rt != 32'd0) begin
                           fin       = 1'b0;
                           div_start = 1'b1;
                           state_in  = S_DIV;
                        end
                     end
                     mics_pkg::FN_ADD, mics_pkg::FN_ADDU: begin
                        fin_wr = 1'b1; fin_val = rs + rt;
                     end
                     mics_pkg::FN_SUB, mics_pkg::FN_SUBU: begin
                        fin_wr = 1'b1; fin_val = rs - rt;
                     end
                     mics_pkg::FN_AND: begin fin_wr = 1'b1; fin_val = rs & rt; end
                     mics_pkg::FN_OR:  begin fin_wr = 1'b1; fin_val = rs | rt; end
                     mics_pkg::FN_XOR: begin fin_wr = 1'b1; fin_val = rs ^ rt; end
                     mics_pkg::FN_NOR: begin fin_wr = 1'b1; fin_val = ~(rs | rt); end
                     mics_pkg::FN_SLT: begin
                        fin_wr = 1'b1; fin_val = {31'd0, $signed(rs) < $signed(rt)};
                     end
                     mics_pkg::FN_SLTU: begin fin_wr = 1'b1; fin_val = {31'd0, rs < rt}; end
                     default: ;
                  endcase
               end
               mics_pkg::OP_REGIMM: begin
                  if (rtn == mics_pkg::RI_BGEZ && !rs[31]) begin
                     pc_in = br;
                  end else if (rtn == mics_pkg::RI_BLTZ && rs[31]) begin
                     pc_in = br;
                  end
               end
               mics_pkg::OP_J: pc_in = jtgt;
               mics_pkg::OP_JAL: begin
                  fin_wr = 1'b1; fin_reg = mics_pkg::LINK_REG; fin_val = npc; pc_in = jtgt;
               end
               mics_pkg::OP_BEQ:  if (rs == rt) pc_in = br;
               mics_pkg::OP_BNE:  if (rs != rt) pc_in = br;
               mics_pkg::OP_BLEZ: if (rs == 32'd0 || rs[31]) pc_in = br;
               mics_pkg::OP_BGTZ: if (rs != 32'd0 && !rs[31]) pc_in = br;
               mics_pkg::OP_ADDI, mics_pkg::OP_ADDIU: begin
                  fin_wr = 1'b1; fin_reg = rtn; fin_val = ea;
               end
               mics_pkg::OP_SLTI: begin
                  fin_wr = 1'b1; fin_reg = rtn;
                  fin_val = {31'd0, $signed(rs) < $signed(imm)};
               end
               mics_pkg::OP_SLTIU: begin
                  fin_wr = 1'b1; fin_reg = rtn; fin_val = {31'd0, rs < imm};
               end
               mics_pkg::OP_ANDI: begin fin_wr = 1'b1; fin_reg = rtn; fin_val = rs & zimm; end
               mics_pkg::OP_ORI:  begin fin_wr = 1'b1; fin_reg = rtn; fin_val = rs | zimm; end
               mics_pkg::OP_XORI: begin fin_wr = 1'b1; fin_reg = rtn; fin_val = rs ^ zimm; end
               mics_pkg::OP_LUI: begin
                  fin_wr = 1'b1; fin_reg = rtn; fin_val = {ins_ff[15:0], 16'd0};
               end
               mics_pkg::OP_LB, mics_pkg::OP_LBU, mics_pkg::OP_SB: begin
                  rsp_in.status = st_b;
                  if (st_b == mics_pkg::ST_OK) begin
                     fin = 1'b0; dm_en = 1'b1; dm_addr = ea[AW+1:2]; state_in = S_MEM;
                  end
               end
               mics_pkg::OP_LH, mics_pkg::OP_LHU, mics_pkg::OP_SH: begin
                  rsp_in.status = st_h;
                  if (st_h == mics_pkg::ST_OK) begin
                     fin = 1'b0; dm_en = 1'b1; dm_addr = ea[AW+1:2]; state_in = S_MEM;
                  end
               end
               mics_pkg::OP_LW: begin
                  fin_reg = rtn;
                  if (ea == {16'd0, key_address_ff}) begin
                     fin_wr = 1'b1; fin_val = req_ff.key_state;
                  end else if (ea == mics_pkg::MOUSE_Y_ADDR) begin
                     fin_wr = 1'b1; fin_val = req_ff.mouse_y;
                  end else if (ea == mics_pkg::MOUSE_X_ADDR) begin
                     fin_wr = 1'b1; fin_val = req_ff.mouse_x;
                  end else begin
                     rsp_in.status = st_w;
                     if (st_w == mics_pkg::ST_OK) begin
                        fin = 1'b0; dm_en = 1'b1; dm_addr = ea[AW+1:2]; state_in = S_MEM;
                     end
                  end
               end
               mics_pkg::OP_SW: begin
                  rsp_in.status = st_w;
                  if (st_w == mics_pkg::ST_OK) begin
                     dm_en       = 1'b1;
                     dm_we       = 1'b1;
                     dm_addr     = ea[AW+1:2];
                     dm_wdata    = rt;
                     rsp_in.gfx_written = (ea == {16'd0, gfx_address_ff});
                  end
               end
               default: ;
            endcase
         end

         S_MEM: begin
            fin     = 1'b1;
            pc_in   = npc_ff;
            fin_reg = rtn;
            dm_addr = addr_ff[AW+1:2];
            case (op)
               mics_pkg::OP_LB: begin
                  fin_wr = 1'b1; fin_val = {{24{byte_w[7]}}, byte_w[7:0]};
               end
               mics_pkg::OP_LBU: begin fin_wr = 1'b1; fin_val = byte_w; end
               mics_pkg::OP_LH: begin
                  fin_wr = 1'b1; fin_val = {{16{half_w[15]}}, half_w[15:0]};
               end
               mics_pkg::OP_LHU: begin fin_wr = 1'b1; fin_val = half_w; end
               mics_pkg::OP_LW:  begin fin_wr = 1'b1; fin_val = dm_rdata; end
               mics_pkg::OP_SB: begin
                  dm_en    = 1'b1;
                  dm_we    = 1'b1;
                  dm_wdata = (dm_rdata & ~(32'h0000_00FF << bsh)) | ({24'd0, rt[7:0]} << bsh);
               end
               mics_pkg::OP_SH: begin
                  dm_en    = 1'b1;
                  dm_we    = 1'b1;
                  dm_wdata = addr_ff[1] ? {rt[15:0], dm_rdata[15:0]}
                                        : {dm_rdata[31:16], rt[15:0]};
               end
               default: ;
            endcase
         end

         S_MUL: begin
            fin   = 1'b1;
            pc_in = npc_ff;
            hi_we = 1'b1;
            lo_we = 1'b1;
            {hi_in, lo_in} = mneg_ff ? 64'd0 - prod_ff : prod_ff;
         end

         S_DIV: begin
            if (div_done) begin
               fin   = 1'b1;
               pc_in = npc_ff;
               hi_we = 1'b1;
               lo_we = 1'b1;
               lo_in = qneg_ff ? 32'd0 - div_q : div_q;
               hi_in = rneg_ff ? 32'd0 - div_r : div_r;
            end
         end

         default: state_in = S_IDLE;
      endcase

      if (fin) begin
         state_in = S_IDLE;
         rsp_in.pc_after = pc_in;
         if (fin_wr && fin_reg != 5'd0) begin
            rsp_in.dest_written = 1'b1;
            rsp_in.dest_reg     = fin_reg;
            rsp_in.dest_value   = fin_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pc_ff        <= '0;
         hi_ff        <= '0;
         lo_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= fin;
         if (fin) begin
            pc_ff <= pc_in;
         end
         if (hi_we) begin
            hi_ff <= hi_in;
         end
         if (lo_we) begin
            lo_ff <= lo_in;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      if (state_ff == S_FETCH) begin
         ins_ff <= dm_rdata;
      end
      if (state_ff == S_EXEC) begin
         addr_ff <= ea;
         npc_ff  <= npc;
         prod_ff <= mprod;
         mneg_ff <= (fn == mics_pkg::FN_MULT) && (rs[31] ^ rt[31]);
         qneg_ff <= (fn == mics_pkg::FN_DIV) && (rs[31] ^ rt[31]);
         rneg_ff <= (fn == mics_pkg::FN_DIV) && rs[31];
      end
      if (fin) begin
         rsp_ff <= rsp_in;
      end
   end

   mics_dmem #(
      .WORDS (MemWordsInt),
      .AW    (AW)
   ) u_dmem (
      .clock (clock),
      .en    (dm_en),
      .we    (dm_we),
      .addr  (dm_addr),
      .wdata (dm_wdata),
      .rdata (dm_rdata)
   );

   mics_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (rf_rd_en),
      .rd_addr_a (dm_rdata[25:21]),
      .rd_addr_b (dm_rdata[20:16]),
      .rd_data_a (rs),
      .rd_data_b (rt),
      .wr_en     (fin && fin_wr),
      .wr_addr   (fin_reg),
      .wr_data   (fin_val)
   );

   mics_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_a),
      .divisor   (div_b),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
   import mics_pkg::*;

   localparam int unsigned MEMB  = 65536;
   localparam int unsigned WORDS = MEMB / 4;
   localparam int unsigned WDOG  = 5000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   req_type    req_data = '0;
   logic       rsp_valid;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [1:0] csr_index = CSR_CODE_OFFSET;
   logic [15:0] csr_wdata = '0;

   mips_integer_core_step #(.MEM_BYTES(MEMB)) u_top (.*);

   // -------------------------------------------------------------------------
   // Shadow copy of the core: registers, hi/lo, pc, word memory and which
   // words have been loaded. Everything is advanced in the order requests are
   // queued, which is the order the core takes them.
   // -------------------------------------------------------------------------
   logic [31:0] gpr [32];
   logic [31:0] hi_q, lo_q, pc_q;
   logic [31:0] mem [WORDS];
   bit          loaded [WORDS];
   logic [31:0] code_off, gfx_addr, key_addr;

   req_type pending_reqs [$];
   rsp_type due_rsps [$];

   bit          took = 1'b0;   // request taken at the last rising edge
   bit          calm = 1'b0;   // no idling in the last stretch
   int unsigned idle_left = 0;
   int unsigned quiet = 0;
   int unsigned n_bad = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [1:0] addr_status(logic [31:0] a, int unsigned size);
      if (a > MEMB - size)         return ST_RANGE;
      if ((a & (size - 1)) != 0)   return ST_MISALIGN;
      return ST_OK;
   endfunction

   // Word index that the next execute request would read as data, if any.
   function automatic bit data_word(output int unsigned idx);
      logic [31:0] ins, a;
      logic [5:0]  op;
      idx = 0;
      if (pc_q > MEMB - 4 || pc_q[1:0] != 2'b00) return 0;
      if (!loaded[pc_q >> 2]) return 0;
      ins = mem[pc_q >> 2];
      op  = ins[31:26];
      a   = gpr[ins[25:21]] + {{16{ins[15]}}, ins[15:0]};
      idx = a >> 2;
      case (op)
         OP_LB, OP_LBU, OP_SB: return addr_status(a, 1) == ST_OK;
         OP_LH, OP_LHU, OP_SH: return addr_status(a, 2) == ST_OK;
         OP_LW: begin
            if (a == key_addr || a == MOUSE_Y_ADDR || a == MOUSE_X_ADDR) return 0;
            return addr_status(a, 4) == ST_OK;
         end
         OP_SW: return addr_status(a, 4) == ST_OK;
         default: return 0;
      endcase
   endfunction

   // One request through the shadow core; returns the response it gives.
   function automatic rsp_type core_step(req_type r);
      rsp_type     o;
      logic [31:0] ins, npc, rs, rt, imm, a, br, nxt, wval, w, ma, mb;
      logic [63:0] p;
      logic [5:0]  op, fn;
      logic [4:0]  rsn, rtn, rdn, sh, wreg;
      logic [4:0]  bs;
      bit          wr;
      o = '0;
      case (r.mode)
         MODE_LOAD: begin
            mem[r.load_index] = r.load_data;
            loaded[r.load_index] = 1'b1;
         end
         MODE_RESTART: pc_q = code_off;
         MODE_EXEC: begin
            if (pc_q > MEMB - 4) o.status = ST_FETCH;
            else if (pc_q[1:0] != 2'b00) o.status = ST_MISALIGN;
            else begin
               ins = mem[pc_q >> 2];
               npc = pc_q + 4;
               op  = ins[31:26];
               rsn = ins[25:21];
               rtn = ins[20:16];
               rdn = ins[15:11];
               sh  = ins[10:6];
               fn  = ins[5:0];
               rs  = gpr[rsn];
               rt  = gpr[rtn];
               imm = {{16{ins[15]}}, ins[15:0]};
               a   = rs + imm;
               br  = npc + (imm << 2);
               nxt = npc;
               wr  = 0;
               wreg = rtn;
               wval = '0;
               case (op)
                  OP_SPECIAL: begin
                     wreg = rdn;
                     case (fn)
                        FN_SLL:  begin wr = 1; wval = rt << sh; end
                        FN_SRL:  begin wr = 1; wval = rt >> sh; end
                        FN_SRA:  begin wr = 1; wval = $signed(rt) >>> sh; end
                        FN_SLLV: begin wr = 1; wval = rt << rs[4:0]; end
                        FN_SRLV: begin wr = 1; wval = rt >> rs[4:0]; end
                        FN_SRAV: begin wr = 1; wval = $signed(rt) >>> rs[4:0]; end
                        FN_JR:   nxt = rs;
                        FN_JALR: begin wr = 1; wval = npc; nxt = rs; end
                        FN_MFHI: begin wr = 1; wval = hi_q; end
                        FN_MTHI: hi_q = rs;
                        FN_MFLO: begin wr = 1; wval = lo_q; end
                        FN_MTLO: lo_q = rs;
                        FN_MULT: begin
                           p = {{32{rs[31]}}, rs} * {{32{rt[31]}}, rt};
                           hi_q = p[63:32]; lo_q = p[31:0];
                        end
                        FN_MULTU: begin
                           p = {32'd0, rs} * {32'd0, rt};
                           hi_q = p[63:32]; lo_q = p[31:0];
                        end
                        FN_DIV: if (rt != 0) begin
                           ma = rs[31] ? -rs : rs;
                           mb = rt[31] ? -rt : rt;
                           lo_q = (rs[31] ^ rt[31]) ? -(ma / mb) : ma / mb;
                           hi_q = rs[31] ? -(ma % mb) : ma % mb;
                        end
                        FN_DIVU: if (rt != 0) begin
                           lo_q = rs / rt; hi_q = rs % rt;
                        end
                        FN_ADD, FN_ADDU: begin wr = 1; wval = rs + rt; end
                        FN_SUB, FN_SUBU: begin wr = 1; wval = rs - rt; end
                        FN_AND:  begin wr = 1; wval = rs & rt; end
                        FN_OR:   begin wr = 1; wval = rs | rt; end
                        FN_XOR:  begin wr = 1; wval = rs ^ rt; end
                        FN_NOR:  begin wr = 1; wval = ~(rs | rt); end
                        FN_SLT:  begin wr = 1; wval = ($signed(rs) < $signed(rt)); end
                        FN_SLTU: begin wr = 1; wval = (rs < rt); end
                        default: ;
                     endcase
                  end
                  OP_REGIMM: begin
                     if (rtn == RI_BGEZ && !rs[31]) nxt = br;
                     else if (rtn == RI_BLTZ && rs[31]) nxt = br;
                  end
                  OP_J, OP_JAL: begin
                     if (op == OP_JAL) begin wr = 1; wreg = LINK_REG; wval = npc; end
                     nxt = code_off + ((npc & 32'hF000_0000) | {4'd0, ins[25:0], 2'b00});
                  end
                  OP_BEQ:  if (rs == rt) nxt = br;
                  OP_BNE:  if (rs != rt) nxt = br;
                  OP_BLEZ: if (rs == 0 || rs[31]) nxt = br;
                  OP_BGTZ: if (rs != 0 && !rs[31]) nxt = br;
                  OP_ADDI, OP_ADDIU: begin wr = 1; wval = rs + imm; end
                  OP_SLTI:  begin wr = 1; wval = ($signed(rs) < $signed(imm)); end
                  OP_SLTIU: begin wr = 1; wval = (rs < imm); end
                  OP_ANDI:  begin wr = 1; wval = rs & {16'd0, ins[15:0]}; end
                  OP_ORI:   begin wr = 1; wval = rs | {16'd0, ins[15:0]}; end
                  OP_XORI:  begin wr = 1; wval = rs ^ {16'd0, ins[15:0]}; end
                  OP_LUI:   begin wr = 1; wval = {ins[15:0], 16'd0}; end
                  OP_LB, OP_LBU: begin
                     o.status = addr_status(a, 1);
                     if (o.status == ST_OK) begin
                        w = (mem[a >> 2] >> (a[1:0] * 8)) & 32'hFF;
                        if (op == OP_LB && w[7]) w |= 32'hFFFF_FF00;
                        wr = 1; wval = w;
                     end
                  end
                  OP_LH, OP_LHU: begin
                     o.status = addr_status(a, 2);
                     if (o.status == ST_OK) begin
                        w = (mem[a >> 2] >> ({a[1], 1'b0} * 8)) & 32'hFFFF;
                        if (op == OP_LH && w[15]) w |= 32'hFFFF_0000;
                        wr = 1; wval = w;
                     end
                  end
                  OP_LW: begin
                     if (a == key_addr) begin wr = 1; wval = r.key_state; end
                     else if (a == MOUSE_Y_ADDR) begin wr = 1; wval = r.mouse_y; end
                     else if (a == MOUSE_X_ADDR) begin wr = 1; wval = r.mouse_x; end
                     else begin
                        o.status = addr_status(a, 4);
                        if (o.status == ST_OK) begin wr = 1; wval = mem[a >> 2]; end
                     end
                  end
                  OP_SB: begin
                     o.status = addr_status(a, 1);
                     if (o.status == ST_OK) begin
                        bs = {a[1:0], 3'b000};
                        mem[a >> 2] = (mem[a >> 2] & ~(32'hFF << bs)) | ((rt & 32'hFF) << bs);
                     end
                  end
                  OP_SH: begin
                     o.status = addr_status(a, 2);
                     if (o.status == ST_OK) begin
                        bs = {a[1], 4'b0000};
                        mem[a >> 2] = (mem[a >> 2] & ~(32'hFFFF << bs)) |
                                      ((rt & 32'hFFFF) << bs);
                     end
                  end
                  OP_SW: begin
                     o.status = addr_status(a, 4);
                     if (o.status == ST_OK) begin
                        mem[a >> 2] = rt;
                        o.gfx_written = (a == gfx_addr);
                     end
                  end
                  default: ;
               endcase
               if (wr && wreg != 0) begin
                  gpr[wreg] = wval;
                  o.dest_written = 1'b1;
                  o.dest_reg = wreg;
                  o.dest_value = wval;
               end
               pc_q = nxt;
            end
         end
         default: ;  // unused mode: nothing moves
      endcase
      o.pc_after = pc_q;
      return o;
   endfunction

   // -------------------------------------------------------------------------
   // Request building
   // -------------------------------------------------------------------------
   function automatic req_type rand_req(logic [1:0] mode);
      req_type r;
      r.mode       = mode;
      r.key_state  = $urandom;
      r.mouse_x    = $urandom;
      r.mouse_y    = $urandom;
      r.load_index = 14'($urandom);
      r.load_data  = $urandom;
      return r;
   endfunction

   task automatic queue_req(req_type r);
      due_rsps.push_back(core_step(r));
      pending_reqs.push_back(r);
   endtask

   task automatic load_word(int unsigned idx, logic [31:0] val);
      req_type r;
      r = rand_req(MODE_LOAD);
      r.load_index = idx[13:0];
      r.load_data  = val;
      queue_req(r);
   endtask

   function automatic logic [31:0] r_ins(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
                                          logic [4:0] rd, logic [4:0] sh);
      return {OP_SPECIAL, rs, rt, rd, sh, fn};
   endfunction

   function automatic logic [31:0] i_ins(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                          logic [15:0] imm);
      return {op, rs, rt, imm};
   endfunction

   // registers 0..7 most of the time so that results feed later instructions
   function automatic logic [4:0] pick_reg();
      return ($urandom_range(0, 3) != 0) ? 5'($urandom_range(0, 7)) : 5'($urandom);
   endfunction

   function automatic logic [31:0] rand_ins();
      logic [5:0]  fns [26] = '{FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV, FN_JR,
                                FN_JALR, FN_MFHI, FN_MTHI, FN_MFLO, FN_MTLO, FN_MULT,
                                FN_MULTU, FN_DIV, FN_DIVU, FN_ADD, FN_ADDU, FN_SUB,
                                FN_SUBU, FN_AND, FN_OR, FN_XOR, FN_NOR, FN_SLT, FN_SLTU};
      logic [5:0]  imms [8] = '{OP_ADDI, OP_ADDIU, OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI,
                                OP_XORI, OP_LUI};
      logic [5:0]  brs [5] = '{OP_REGIMM, OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ};
      logic [5:0]  mems [8] = '{OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU, OP_SB, OP_SH, OP_SW};
      logic [5:0]  op, fn;
      logic [4:0]  rs, rt;
      logic [31:0] d, diff, tgt;
      int unsigned size;
      rs = pick_reg();
      rt = pick_reg();
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            fn = ($urandom_range(0, 15) == 0) ? 6'($urandom) : fns[$urandom_range(0, 25)];
            // jumps through a register mostly land badly; keep them rarer
            if ((fn == FN_JR || fn == FN_JALR) && $urandom_range(0, 2) != 0) fn = FN_ADDU;
            return r_ins(fn, rs, rt, pick_reg(), 5'($urandom));
         end
         3: return i_ins(imms[$urandom_range(0, 7)], rs, rt, 16'($urandom));
         4: begin
            op = brs[$urandom_range(0, 4)];
            if (op == OP_REGIMM && $urandom_range(0, 3) != 0) rt = 5'($urandom_range(0, 1));
            return i_ins(op, rs, rt, 16'($signed($urandom_range(0, 16)) - 8));
         end
         5: begin
            tgt = ((pc_q - code_off) >> 2) + $urandom_range(0, 16) - 6;
            if ($urandom_range(0, 7) == 0) tgt = $urandom;
            return {($urandom_range(0, 1) ? OP_JAL : OP_J), tgt[25:0]};
         end
         6, 7, 8: begin
            op = mems[$urandom_range(0, 7)];
            size = (op == OP_LW || op == OP_SW) ? 4 :
                   (op == OP_LH || op == OP_LHU || op == OP_SH) ? 2 : 1;
            case ($urandom_range(0, 7))
               0, 1, 2: d = ($urandom_range(16'h0200, 16'h03FF)) & ~(size - 1);
               3: case ($urandom_range(0, 3))
                     0: d = key_addr;
                     1: d = MOUSE_Y_ADDR;
                     2: d = MOUSE_X_ADDR;
                     default: d = gfx_addr;
                  endcase
               4: d = MEMB - $urandom_range(0, 8);
               5: d = $urandom_range(0, 16'hFFFF) | 1;
               6: d = $urandom_range(0, 16'hFFFF) & ~(size - 1);
               default: d = $urandom;
            endcase
            diff = d - gpr[rs];
            if ($signed(diff) < -32768 || $signed(diff) > 32767) begin
               if (d < 32768) begin rs = 5'd0; diff = d; end
               else diff = $urandom;
            end
            return i_ins(op, rs, rt, diff[15:0]);
         end
         default: return $urandom;
      endcase
   endfunction

   // One execute request: place an instruction at pc when needed and make
   // sure the data word it touches has been loaded.
   task automatic exec_one(bit fixed, logic [31:0] ins);
      req_type     r;
      int unsigned idx;
      if (pc_q <= MEMB - 4 && pc_q[1:0] == 2'b00) begin
         if (fixed) load_word(pc_q >> 2, ins);
         else if (!loaded[pc_q >> 2] || $urandom_range(0, 1)) load_word(pc_q >> 2, rand_ins());
         if (data_word(idx) && !loaded[idx]) load_word(idx, $urandom);
      end
      r = rand_req(MODE_EXEC);
      queue_req(r);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [15:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      case (idx)
         CSR_CODE_OFFSET: code_off = val;
         CSR_GFX_ADDRESS: gfx_addr = val;
         CSR_KEY_ADDRESS: key_addr = val;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      wait (pending_reqs.size() == 0 && due_rsps.size() == 0);
      repeat (5) @(posedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Driver: changes inputs on the falling edge
   // -------------------------------------------------------------------------
   always @(negedge clock) begin : drive
      req_type nx;
      bit      st;
      nx = req_data;
      st = 1'b0;
      if (reset) st = 1'b0;
      else if (start && !took) st = 1'b1;       // request still waiting
      else if (idle_left > 0) idle_left--;
      else if (pending_reqs.size() > 0) begin
         if (!calm && $urandom_range(0, 9) == 0) idle_left = $urandom_range(0, 7);
         else begin
            nx = pending_reqs.pop_front();
            st = 1'b1;
         end
      end
      start    <= st;
      req_data <= nx;
   end

   // -------------------------------------------------------------------------
   // Monitor: sample on the rising edge, compare against the oldest forecast
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : watch
      rsp_type e;
      took <= start && !busy && !reset;
      if (reset || (start && !busy) || rsp_valid) quiet <= 0;
      else quiet <= quiet + 1;
      if (!reset && rsp_valid) begin
         if (due_rsps.size() == 0) begin
            n_bad++;
            if (n_bad <= 10) $display("unexpected response %h", rsp_data);
         end else begin
            e = due_rsps.pop_front();
            if (rsp_data.status !== e.status || rsp_data.pc_after !== e.pc_after ||
                rsp_data.dest_written !== e.dest_written ||
                rsp_data.dest_reg !== e.dest_reg ||
                rsp_data.dest_value !== e.dest_value ||
                rsp_data.gfx_written !== e.gfx_written) begin
               n_bad++;
               if (n_bad <= 10)
                  $display("mismatch: status %0d/%0d pc %h/%h dw %b/%b rd %0d/%0d dv %h/%h gfx %b/%b",
                           e.status, rsp_data.status, e.pc_after, rsp_data.pc_after,
                           e.dest_written, rsp_data.dest_written, e.dest_reg,
                           rsp_data.dest_reg, e.dest_value, rsp_data.dest_value,
                           e.gfx_written, rsp_data.gfx_written);
            end
         end
      end
   end

   // watchdog: too long with no request taken and no response
   always @(posedge clock) begin
      if (quiet >= WDOG) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin : stim
      logic [15:0] offs [5] = '{16'd0, 16'hFFFC, 16'h4000, 16'h1234, 16'h0100};
      logic [15:0] gfxs [5] = '{16'h0300, 16'hFFFF, 16'h0000, 16'h0204, 16'hFFFC};
      logic [15:0] keys [5] = '{16'h0000, 16'hFFFF, 16'h0208, 16'h0101, 16'h00FC};
      int unsigned k;
      for (int i = 0; i < 32; i++) gpr[i] = '0;
      hi_q = '0; lo_q = '0; pc_q = '0;
      code_off = '0; gfx_addr = '0; key_addr = '0;
      for (int i = 0; i < WORDS; i++) begin mem[i] = '0; loaded[i] = 0; end

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: hi/lo corner cases, mapped loads, faults, link and branches
      exec_one(1, i_ins(OP_LUI, 5'd0, 5'd1, 16'h8000));
      exec_one(1, i_ins(OP_ADDIU, 5'd0, 5'd2, 16'hFFFF));
      exec_one(1, r_ins(FN_DIV, 5'd1, 5'd2, 5'd0, 5'd0));      // most negative / -1
      exec_one(1, r_ins(FN_MFLO, 5'd0, 5'd0, 5'd3, 5'd0));
      exec_one(1, r_ins(FN_MFHI, 5'd0, 5'd0, 5'd4, 5'd0));
      exec_one(1, r_ins(FN_DIV, 5'd1, 5'd0, 5'd0, 5'd0));      // divide by zero
      exec_one(1, r_ins(FN_MFLO, 5'd0, 5'd0, 5'd5, 5'd0));
      exec_one(1, r_ins(FN_MULT, 5'd1, 5'd2, 5'd0, 5'd0));
      exec_one(1, r_ins(FN_MFHI, 5'd0, 5'd0, 5'd6, 5'd0));
      exec_one(1, r_ins(FN_MULTU, 5'd2, 5'd2, 5'd0, 5'd0));
      exec_one(1, r_ins(FN_MFHI, 5'd0, 5'd0, 5'd7, 5'd0));
      exec_one(1, r_ins(FN_SRAV, 5'd2, 5'd1, 5'd8, 5'd0));
      exec_one(1, r_ins(FN_ADDU, 5'd2, 5'd2, 5'd0, 5'd0));     // write to r0 dropped
      exec_one(1, i_ins(OP_LW, 5'd0, 5'd9, 16'h00FB));
      exec_one(1, i_ins(OP_LW, 5'd0, 5'd10, 16'h00FC));
      exec_one(1, i_ins(OP_LW, 5'd0, 5'd11, 16'h0000));        // key word
      exec_one(1, i_ins(OP_SW, 5'd0, 5'd2, 16'h0000));         // graphics word
      exec_one(1, i_ins(OP_LH, 5'd0, 5'd12, 16'h0201));        // misaligned
      exec_one(1, i_ins(OP_ORI, 5'd0, 5'd13, 16'hFFFF));
      exec_one(1, i_ins(OP_LW, 5'd13, 5'd12, 16'h0000));       // beyond memory
      exec_one(1, {OP_REGIMM, 5'd2, RI_BLTZ, 16'd1});
      exec_one(1, r_ins(FN_JALR, 5'd0, 5'd0, 5'd14, 5'd0));
      queue_req(rand_req(2'd3));                                // unused mode
      queue_req(rand_req(MODE_RESTART));
      drain();

      // random phases, each under its own register settings
      for (int ph = 0; ph < 5; ph++) begin
         write_csr(CSR_CODE_OFFSET, offs[ph]);
         write_csr(CSR_GFX_ADDRESS, gfxs[ph]);
         write_csr(CSR_KEY_ADDRESS, keys[ph]);
         if (ph == 4) calm = 1'b1;
         for (int n = 0; n < 200; n++) begin
            k = $urandom_range(0, 99);
            if ((pc_q > MEMB - 4 || pc_q[1:0] != 2'b00) && k < 70) k = 0;
            if (k < 6) queue_req(rand_req(MODE_RESTART));
            else if (k < 9) queue_req(rand_req(2'd3));
            else if (k < 13) queue_req(rand_req(MODE_LOAD));
            else exec_one(0, '0);
         end
         drain();
      end

      repeat (60) @(posedge clock);
      if (n_bad == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule

// ----- mips_integer_core_step.f -----
rtl/mics_pkg.sv
rtl/mics_regfile.sv
rtl/mics_dmem.sv
rtl/mics_div.sv
rtl/mips_integer_core_step.sv
dv/tb_top.sv
